### sv/assert_macros.svh
// assertion macros used by ray_box_slab_test
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property checked while reset is low
`define RBST_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rbst assertion failed");
// property checked in every cycle, reset included
`define RBST_ASSERT_ALL(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("rbst assertion failed");
`else
`define RBST_ASSERT(lbl, clk, rst, prop)
`define RBST_ASSERT_ALL(lbl, clk, prop)
`endif
`endif

### sv/rbst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_pkg
// shared types and constants of the ray / box slab test
// ----------------------------------------------------------------------------
package rbst_pkg;
   localparam int unsigned THR_WIDTH = 16;
   localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd7;
   typedef logic [THR_WIDTH-1:0] thr_type;
endpackage

### sv/rbst_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_req_if
// request channel: one ray and one box per item
// ----------------------------------------------------------------------------
interface rbst_req_if #(parameter int COORD_WIDTH = 32);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] origin_x;
   logic signed [COORD_WIDTH-1:0] origin_y;
   logic signed [COORD_WIDTH-1:0] origin_z;
   logic signed [COORD_WIDTH-1:0] dir_x;
   logic signed [COORD_WIDTH-1:0] dir_y;
   logic signed [COORD_WIDTH-1:0] dir_z;
   logic signed [COORD_WIDTH-1:0] box_min_x;
   logic signed [COORD_WIDTH-1:0] box_min_y;
   logic signed [COORD_WIDTH-1:0] box_min_z;
   logic signed [COORD_WIDTH-1:0] box_max_x;
   logic signed [COORD_WIDTH-1:0] box_max_y;
   logic signed [COORD_WIDTH-1:0] box_max_z;
   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
      box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
      box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, output ready);
endinterface

### sv/rbst_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_rsp_if
// response channel: one hit flag per item
// ----------------------------------------------------------------------------
interface rbst_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   modport source (output valid, hit, input ready);
   modport sink (input valid, hit, output ready);
endinterface

### sv/rbst_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_csr_if
// register write channel for the parallel threshold
// ----------------------------------------------------------------------------
interface rbst_csr_if;
   import rbst_pkg::*;
   logic valid;
   logic ready;
   thr_type data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

### sv/ray_box_slab_test.sv
// req to rsp passes the input, prep, divider, f1, f2 and rsp/hit registers
// throughput: one item per cycle unless rsp stalls; one restoring stage per quotient bit
// a stalled rsp freezes the whole pipeline, nothing is dropped or repeated
// reset (synchronous, active high) clears all valid bits and sets the threshold to 7
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// ray_box_slab_test
// pipelined ray / axis-aligned box slab test with six restoring dividers
// ----------------------------------------------------------------------------
module ray_box_slab_test #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input logic clock,
   input logic reset,
   rbst_req_if.sink   req,
   rbst_rsp_if.source rsp,
   rbst_csr_if.sink   csr
);
   import rbst_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int NL = 6;               // lanes: 0..2 min numerators, 3..5 max numerators
   localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

   // one division lane as it travels down the pipe
   typedef struct packed {
      logic          par;     // direction counts as parallel
      logic          numneg;  // numerator negative
      logic          neg;     // quotient negative
      logic          ovf;     // integer part too large
      logic [CW-1:0] d;       // divisor magnitude
      logic [CW-1:0] rem;     // partial remainder
      logic [CW-1:0] low;     // numerator bits not yet shifted in
      logic [CW-1:0] quo;     // quotient bits so far
   } lane_type;

   // whole pipe moves when the output register is free or being taken
   logic adv;
   logic rsp_v_ff;
   assign adv       = !rsp_v_ff || rsp.ready;
   assign req.ready = adv;
   assign csr.ready = 1'b1;

   // threshold register
   thr_type thr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr.valid) begin
         thr_ff <= csr.data;
      end
   end

   // input register
   logic          in_v_ff;
   logic [CW-1:0] org_ff [3];
   logic [CW-1:0] dir_ff [3];
   logic [CW-1:0] lo_ff  [3];
   logic [CW-1:0] hi_ff  [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (adv) begin
         in_v_ff <= req.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         org_ff[0] <= req.origin_x;
         org_ff[1] <= req.origin_y;
         org_ff[2] <= req.origin_z;
         dir_ff[0] <= req.dir_x;
         dir_ff[1] <= req.dir_y;
         dir_ff[2] <= req.dir_z;
         lo_ff[0]  <= req.box_min_x;
         lo_ff[1]  <= req.box_min_y;
         lo_ff[2]  <= req.box_min_z;
         hi_ff[0]  <= req.box_max_x;
         hi_ff[1]  <= req.box_max_y;
         hi_ff[2]  <= req.box_max_z;
      end
   end

   // prep: numerators, magnitudes, parallel test and integer overflow test
   lane_type prep_in [NL];
   always_comb begin
      logic signed [CW:0] num;
      logic [CW:0]        nmag;
      logic [CW-1:0]      dmag;
      logic [CW:0]        top;
      logic               dneg;
      for (int l = 0; l < NL; l++) begin
         if (l < 3) begin
            num = $signed({lo_ff[l % 3][CW-1], lo_ff[l % 3]})
                - $signed({org_ff[l % 3][CW-1], org_ff[l % 3]});
         end else begin
            num = $signed({hi_ff[l % 3][CW-1], hi_ff[l % 3]})
                - $signed({org_ff[l % 3][CW-1], org_ff[l % 3]});
         end
         dneg = dir_ff[l % 3][CW-1];
         dmag = dneg ? (~dir_ff[l % 3] + 1'b1) : dir_ff[l % 3];
         nmag = num[CW] ? (~num + 1'b1) : num;
         top  = nmag >> (CW - FRAC_BITS);
         prep_in[l].par    = (dmag == '0) || (dmag < CW'(thr_ff));
         prep_in[l].numneg = num[CW];
         prep_in[l].neg    = num[CW] ^ dneg;
         prep_in[l].ovf    = top >= {1'b0, dmag};
         prep_in[l].d      = dmag;
         prep_in[l].rem    = top[CW-1:0];
         prep_in[l].low    = CW'(nmag << FRAC_BITS);
         prep_in[l].quo    = '0;
      end
   end

   // divider stages: st_ff[0] holds prep, each further stage adds one quotient bit
   logic     st_v_ff [CW+1];
   lane_type st_ff   [CW+1][NL];
   lane_type st_in   [CW+1][NL];
   always_comb begin
      logic [CW:0] t;
      logic        ge;
      for (int l = 0; l < NL; l++) begin
         st_in[0][l] = prep_in[l];
      end
      for (int s = 0; s < CW; s++) begin
         for (int l = 0; l < NL; l++) begin
            t  = {st_ff[s][l].rem, st_ff[s][l].low[CW-1]};
            ge = t >= {1'b0, st_ff[s][l].d};
            st_in[s+1][l]     = st_ff[s][l];
            st_in[s+1][l].rem = ge ? CW'(t - {1'b0, st_ff[s][l].d}) : t[CW-1:0];
            st_in[s+1][l].low = {st_ff[s][l].low[CW-2:0], 1'b0};
            st_in[s+1][l].quo = {st_ff[s][l].quo[CW-2:0], ge};
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= CW; s++) st_v_ff[s] <= 1'b0;
      end else if (adv) begin
         st_v_ff[0] <= in_v_ff;
         for (int s = 1; s <= CW; s++) st_v_ff[s] <= st_v_ff[s-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s <= CW; s++) begin
            for (int l = 0; l < NL; l++) st_ff[s][l] <= st_in[s][l];
         end
      end
   end

   // saturate each distance and order each axis pair
   logic signed [CW-1:0] tdist [NL];
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         priority if (st_ff[CW][l].par) begin
            tdist[l] = st_ff[CW][l].numneg ? T_MIN : T_MAX;
         end else if (st_ff[CW][l].ovf) begin
            tdist[l] = st_ff[CW][l].neg ? T_MIN : T_MAX;
         end else if (st_ff[CW][l].neg) begin
            tdist[l] = st_ff[CW][l].quo[CW-1] ? T_MIN : $signed(~st_ff[CW][l].quo + 1'b1);
         end else begin
            tdist[l] = st_ff[CW][l].quo[CW-1] ? T_MAX : $signed(st_ff[CW][l].quo);
         end
      end
   end

   logic                 f1_v_ff;
   logic signed [CW-1:0] tin_ff  [3];
   logic signed [CW-1:0] tout_ff [3];
   logic                 f2_v_ff;
   logic signed [CW-1:0] enter_ff;
   logic signed [CW-1:0] leave_ff;
   logic signed [CW-1:0] enter_in;
   logic signed [CW-1:0] leave_in;
   logic                 hit_ff;

   // largest entry, smallest exit
   always_comb begin
      enter_in = tin_ff[0];
      leave_in = tout_ff[0];
      for (int a = 1; a < 3; a++) begin
         if (tin_ff[a] > enter_in) enter_in = tin_ff[a];
         if (tout_ff[a] < leave_in) leave_in = tout_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff  <= 1'b0;
         f2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         f1_v_ff  <= st_v_ff[CW];
         f2_v_ff  <= f1_v_ff;
         rsp_v_ff <= f2_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            if (tdist[a] > tdist[a+3]) begin
               tin_ff[a]  <= tdist[a+3];
               tout_ff[a] <= tdist[a];
            end else begin
               tin_ff[a]  <= tdist[a];
               tout_ff[a] <= tdist[a+3];
            end
         end
         enter_ff <= enter_in;
         leave_ff <= leave_in;
         hit_ff   <= enter_ff <= leave_ff;
      end
   end

   assign rsp.valid = rsp_v_ff;
   assign rsp.hit   = hit_ff;

   // checks
   `RBST_ASSERT_ALL(a_reset_clears, clock, reset |=> !rsp_v_ff && !f2_v_ff && !st_v_ff[0])
   `RBST_ASSERT(a_freeze, clock, reset, !adv |=> $stable(f2_v_ff) && $stable(st_v_ff[CW]))
   for (genvar g = 0; g < NL; g++) begin : g_chk
      logic div_on;
      logic rem_ok;
      assign div_on = st_v_ff[CW] && !st_ff[CW][g].par && !st_ff[CW][g].ovf;
      assign rem_ok = st_ff[CW][g].rem < st_ff[CW][g].d;
      `RBST_ASSERT(a_rem_bound, clock, reset, div_on |-> rem_ok)
   end

endmodule
